/* hdl/qla_pkg.sv */
// Shared types, constants and helpers of the Q-learning agent.
`default_nettype none
package qla_pkg;

  localparam int STATE_COUNT = 256;
  localparam int MAX_ACTIONS = 16;
  localparam int Q_W         = 32;
  localparam int STATE_W     = $clog2(STATE_COUNT);
  localparam int ACT_W       = $clog2(MAX_ACTIONS);
  localparam int ADDR_W      = STATE_W + ACT_W;
  localparam int IDX_W       = 20;
  localparam int SAT_W       = 40;

  typedef enum logic [2:0] {
    CFG_LEARN_ENABLE  = 3'd0,
    CFG_STATE_RADIX   = 3'd1,
    CFG_ACTION_COUNT  = 3'd2,
    CFG_LEARN_RATE    = 3'd3,
    CFG_DISCOUNT      = 3'd4,
    CFG_EPS_STEP      = 3'd5,
    CFG_EPS_FLOOR     = 3'd6,
    CFG_DECAY_PERIOD  = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_PACK, ST_CHECK, ST_MAXSCAN, ST_MULDISC, ST_TARGET,
    ST_BLEND, ST_WRITE, ST_DIVPER, ST_EPS, ST_CHOOSE, ST_DIVPICK, ST_ARGSCAN,
    ST_RESULT
  } st_e;

  typedef struct packed {
    logic        learning_enable;
    logic [4:0]  state_radix;
    logic [4:0]  action_count;
    logic [15:0] learn_rate;
    logic [15:0] discount;
    logic [15:0] epsilon_step;
    logic [15:0] epsilon_floor;
    logic [15:0] decay_period;
  } cfg_t;

  typedef struct packed {
    logic clear_step;
    logic latch;
    logic pack_step;
    logic scan_clr;
    logic scan_step;
    logic rd_prior;
    logic mul_disc;
    logic target;
    logic mul_blend;
    logic write_back;
    logic div_start;
    logic div_sel;
    logic eps_update;
    logic choose;
    logic result;
    logic result_err;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic pack_done;
    logic idx_bad;
    logic learn_prior;
    logic scan_done;
    logic div_done;
    logic explore;
  } stat_t;

  // Clamp to the signed range of a Q entry.
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'((64'sd1 <<< (Q_W - 1)) - 64'sd1);
    lo = -hi - SAT_W'(1);
    if (v > hi) begin
      return Q_W'(hi);
    end else if (v < lo) begin
      return Q_W'(lo);
    end
    return Q_W'(v);
  endfunction

endpackage
`default_nettype wire

/* hdl/qla_div.sv */
// Restoring radix-2 remainder unit, one quotient bit per cycle.
`default_nettype none
module qla_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic             done_o,
  output logic [15:0]      rem_o
);
  logic [16:0] rem_q, rem_d;
  logic [31:0] quo_q;
  logic [15:0] dvs_q;
  logic [4:0]  cnt_q;
  logic        run_q, done_q;
  logic [16:0] trial;

  always_comb begin
    trial = {rem_q[15:0], quo_q[31]};
    rem_d = (trial >= {1'b0, dvs_q}) ? trial - {1'b0, dvs_q} : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[30:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[15:0];
endmodule
`default_nettype wire

/* hdl/qla_datapath.sv */
// Datapath: Q table memory, state packing, row scan, update arithmetic, epsilon.
`default_nettype none
module qla_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire qla_pkg::cfg_t               cfg_i,
  input  wire qla_pkg::cmd_t               cmd_i,
  output qla_pkg::stat_t                   stat_o,
  input  wire logic [3:0]                  obs_0_i,
  input  wire logic [3:0]                  obs_1_i,
  input  wire logic [3:0]                  obs_2_i,
  input  wire logic [3:0]                  obs_3_i,
  input  wire logic signed [31:0]          reward_i,
  input  wire logic [15:0]                 rand_fraction_i,
  input  wire logic [15:0]                 rand_pick_i,
  output logic [3:0]                       action_o,
  output logic [15:0]                      explore_prob_o,
  output logic                             state_error_o,
  output logic                             done_o
);
  import qla_pkg::*;

  logic [Q_W-1:0]          mem [STATE_COUNT*MAX_ACTIONS];
  logic signed [Q_W-1:0]   rdata_q;
  logic [ADDR_W-1:0]       raddr, waddr;
  logic [Q_W-1:0]          wdata;
  logic                    wen;

  logic [3:0]              obs0_q, obs1_q, obs2_q;
  logic signed [31:0]      reward_q;
  logic [15:0]             frac_q, pick_q;
  logic [IDX_W-1:0]        acc_q;
  logic [1:0]              pack_cnt_q;
  logic [IDX_W+4:0]        acc_mul;
  logic [3:0]              digit;
  logic [STATE_W-1:0]      s;

  logic [ACT_W:0]          n_act;
  logic [ACT_W:0]          scan_cnt_q;
  logic signed [Q_W-1:0]   best_val_q;
  logic [ACT_W-1:0]        best_idx_q;

  logic [STATE_W-1:0]      prior_state_q;
  logic [ACT_W-1:0]        prior_action_q;
  logic                    prior_valid_q;

  logic signed [48:0]      prod_q;
  logic signed [Q_W-1:0]   target_q, old_q;
  logic signed [49:0]      p1_q;
  logic signed [48:0]      p2_q;
  logic signed [16:0]      disc_s, lr_s;
  logic signed [17:0]      om_s;
  logic signed [48:0]      prod_r;
  logic signed [SAT_W-1:0] tgt_sum;
  logic signed [50:0]      blend_sum;
  logic signed [Q_W-1:0]   new_q;

  logic [15:0]             eps_q, eps_dec;
  logic [31:0]             step_cnt_q;
  logic                    explore_q;
  logic [ADDR_W-1:0]       clr_cnt_q;

  logic                    div_done;
  logic [15:0]             div_rem;
  logic [31:0]             div_dividend;
  logic [15:0]             div_divisor;
  logic [ACT_W-1:0]        act_sel;

  logic [3:0]              action_q;
  logic [15:0]             eps_out_q;
  logic                    err_q, done_q;

  always_comb begin
    if (cfg_i.action_count == '0) begin
      n_act = (ACT_W+1)'(1);
    end else if (cfg_i.action_count > 5'(MAX_ACTIONS)) begin
      n_act = (ACT_W+1)'(MAX_ACTIONS);
    end else begin
      n_act = (ACT_W+1)'(cfg_i.action_count);
    end
  end

  always_comb begin
    case (pack_cnt_q)
      2'd0:    digit = obs2_q;
      2'd1:    digit = obs1_q;
      default: digit = obs0_q;
    endcase
  end
  assign acc_mul = acc_q * cfg_i.state_radix;
  assign s       = acc_q[STATE_W-1:0];

  assign raddr = cmd_i.rd_prior ? {prior_state_q, prior_action_q}
                                : {s, scan_cnt_q[ACT_W-1:0]};

  // Update arithmetic: halves round toward plus infinity.
  assign disc_s    = {1'b0, cfg_i.discount};
  assign lr_s      = {1'b0, cfg_i.learn_rate};
  assign om_s      = {1'b0, 17'(17'h10000 - {1'b0, cfg_i.learn_rate})};
  assign prod_r    = prod_q + 49'sd32768;
  assign tgt_sum   = SAT_W'(reward_q) + SAT_W'($signed(prod_r[48:16]));
  assign blend_sum = 51'(p1_q) + 51'(p2_q) + 51'sd32768;
  assign new_q     = sat_q(SAT_W'($signed(blend_sum[50:16])));

  assign wen   = cmd_i.clear_step | cmd_i.write_back;
  assign waddr = cmd_i.clear_step ? clr_cnt_q : {prior_state_q, prior_action_q};
  assign wdata = cmd_i.clear_step ? '0 : new_q;

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign div_dividend = cmd_i.div_sel ? {16'd0, pick_q} : step_cnt_q;
  assign div_divisor  = cmd_i.div_sel ? 16'(n_act)
                      : ((cfg_i.decay_period == '0) ? 16'd1 : cfg_i.decay_period);

  qla_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign eps_dec = (eps_q > cfg_i.epsilon_step) ? eps_q - cfg_i.epsilon_step : 16'd0;
  assign act_sel = explore_q ? div_rem[ACT_W-1:0] : best_idx_q;

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      obs0_q   <= obs_0_i;
      obs1_q   <= obs_1_i;
      obs2_q   <= obs_2_i;
      reward_q <= reward_i;
      frac_q   <= rand_fraction_i;
      pick_q   <= rand_pick_i;
      acc_q    <= IDX_W'(obs_3_i);
    end else if (cmd_i.pack_step) begin
      acc_q <= IDX_W'(acc_mul) + IDX_W'(digit);
    end
    if (cmd_i.scan_step && scan_cnt_q != '0) begin
      if (scan_cnt_q == (ACT_W+1)'(1) || rdata_q > best_val_q) begin
        best_val_q <= rdata_q;
        best_idx_q <= ACT_W'(scan_cnt_q - (ACT_W+1)'(1));
      end
    end
    if (cmd_i.mul_disc) begin
      prod_q <= disc_s * best_val_q;
    end
    if (cmd_i.target) begin
      target_q <= sat_q(tgt_sum);
      old_q    <= rdata_q;
    end
    if (cmd_i.mul_blend) begin
      p1_q <= om_s * old_q;
      p2_q <= lr_s * target_q;
    end
    if (cmd_i.result) begin
      action_q  <= cmd_i.result_err ? 4'd0 : 4'(act_sel);
      eps_out_q <= eps_q;
      err_q     <= cmd_i.result_err;
    end
  end

  // Control state of the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_cnt_q     <= '0;
      scan_cnt_q     <= '0;
      prior_state_q  <= '0;
      prior_action_q <= '0;
      prior_valid_q  <= 1'b0;
      eps_q          <= 16'hFFFF;
      step_cnt_q     <= '0;
      explore_q      <= 1'b0;
      clr_cnt_q      <= '0;
      done_q         <= 1'b0;
    end else begin
      if (cmd_i.latch) begin
        pack_cnt_q <= '0;
      end else if (cmd_i.pack_step) begin
        pack_cnt_q <= pack_cnt_q + 2'd1;
      end
      if (cmd_i.scan_clr) begin
        scan_cnt_q <= '0;
      end else if (cmd_i.scan_step) begin
        scan_cnt_q <= scan_cnt_q + (ACT_W+1)'(1);
      end
      if (cmd_i.clear_step) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
      if (cmd_i.eps_update && div_rem == '0) begin
        eps_q <= (eps_dec > cfg_i.epsilon_floor) ? eps_dec : cfg_i.epsilon_floor;
      end
      if (cmd_i.choose) begin
        explore_q <= frac_q < eps_q;
      end
      if (cmd_i.result && !cmd_i.result_err) begin
        step_cnt_q <= step_cnt_q + 32'd1;
        if (cfg_i.learning_enable) begin
          prior_state_q  <= s;
          prior_action_q <= act_sel;
          prior_valid_q  <= 1'b1;
        end
      end
      done_q <= cmd_i.result;
    end
  end

  always_comb begin
    stat_o.clear_done  = clr_cnt_q == '1;
    stat_o.pack_done   = pack_cnt_q == 2'd2;
    stat_o.idx_bad     = |acc_q[IDX_W-1:STATE_W];
    stat_o.learn_prior = cfg_i.learning_enable & prior_valid_q;
    stat_o.scan_done   = scan_cnt_q == n_act;
    stat_o.div_done    = div_done;
    stat_o.explore     = frac_q < eps_q;
  end

  assign action_o       = action_q;
  assign explore_prob_o = eps_out_q;
  assign state_error_o  = err_q;
  assign done_o         = done_q;
endmodule
`default_nettype wire

/* hdl/qla_ctrl.sv */
// Sequencer of one agent step over the datapath.
`default_nettype none
module qla_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire qla_pkg::stat_t stat_i,
  output qla_pkg::cmd_t       cmd_o,
  output logic                busy_o
);
  import qla_pkg::*;

  st_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_PACK;
        end
      end
      ST_PACK: begin
        cmd_o.pack_step = 1'b1;
        if (stat_i.pack_done) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.scan_clr = 1'b1;
        if (stat_i.idx_bad) begin
          cmd_o.result     = 1'b1;
          cmd_o.result_err = 1'b1;
          state_d          = ST_IDLE;
        end else if (stat_i.learn_prior) begin
          state_d = ST_MAXSCAN;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIVPER;
        end
      end
      ST_MAXSCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) state_d = ST_MULDISC;
      end
      ST_MULDISC: begin
        cmd_o.mul_disc = 1'b1;
        cmd_o.rd_prior = 1'b1;
        state_d        = ST_TARGET;
      end
      ST_TARGET: begin
        cmd_o.target = 1'b1;
        state_d      = ST_BLEND;
      end
      ST_BLEND: begin
        cmd_o.mul_blend = 1'b1;
        state_d         = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.write_back = 1'b1;
        cmd_o.div_start  = 1'b1;
        state_d          = ST_DIVPER;
      end
      ST_DIVPER: begin
        if (stat_i.div_done) state_d = ST_EPS;
      end
      ST_EPS: begin
        cmd_o.eps_update = 1'b1;
        state_d          = ST_CHOOSE;
      end
      ST_CHOOSE: begin
        cmd_o.choose = 1'b1;
        if (stat_i.explore) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = 1'b1;
          state_d         = ST_DIVPICK;
        end else begin
          cmd_o.scan_clr = 1'b1;
          state_d        = ST_ARGSCAN;
        end
      end
      ST_DIVPICK: begin
        cmd_o.div_sel = 1'b1;
        if (stat_i.div_done) state_d = ST_RESULT;
      end
      ST_ARGSCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        cmd_o.result = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

/* hdl/tabular_q_learning_agent_top.sv */
// Top level of the tabular Q-learning agent with epsilon-greedy action choice.
// A request taken at start_i runs through the sequencer; each 32-bit remainder run holds
// the sequencer and each row scan goes over the Q table's single read port. A bad state
// index returns straight from the index check.
// One request is in flight at a time; the result strobe done_o lasts one cycle and
// cannot be stalled. After reset the whole table is cleared with busy_o high.
`default_nettype none
module tabular_q_learning_agent_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [3:0]         obs_0_i,
  input  wire logic [3:0]         obs_1_i,
  input  wire logic [3:0]         obs_2_i,
  input  wire logic [3:0]         obs_3_i,
  input  wire logic signed [31:0] reward_i,
  input  wire logic [15:0]        rand_fraction_i,
  input  wire logic [15:0]        rand_pick_i,
  output logic                    done_o,
  output logic [3:0]              action_o,
  output logic [15:0]             explore_prob_o,
  output logic                    state_error_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i
);
  import qla_pkg::*;

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;

  // Configuration registers; each write lands at once and also affects a request
  // already in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learning_enable <= 1'b1;
      cfg_q.state_radix     <= 5'd2;
      cfg_q.action_count    <= 5'd16;
      cfg_q.learn_rate      <= 16'd13107;
      cfg_q.discount        <= 16'd58982;
      cfg_q.epsilon_step    <= 16'd655;
      cfg_q.epsilon_floor   <= 16'd3277;
      cfg_q.decay_period    <= 16'd100;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LEARN_ENABLE: cfg_q.learning_enable <= cfg_data_i[0];
        CFG_STATE_RADIX:  cfg_q.state_radix     <= cfg_data_i[4:0];
        CFG_ACTION_COUNT: cfg_q.action_count    <= cfg_data_i[4:0];
        CFG_LEARN_RATE:   cfg_q.learn_rate      <= cfg_data_i;
        CFG_DISCOUNT:     cfg_q.discount        <= cfg_data_i;
        CFG_EPS_STEP:     cfg_q.epsilon_step    <= cfg_data_i;
        CFG_EPS_FLOOR:    cfg_q.epsilon_floor   <= cfg_data_i;
        CFG_DECAY_PERIOD: cfg_q.decay_period    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The controller clears the table after reset, then walks one request through packing,
  // the index check, the optional table update, epsilon decay and action choice.
  qla_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  // The datapath owns the Q table and all arithmetic.
  qla_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .obs_0_i        (obs_0_i),
    .obs_1_i        (obs_1_i),
    .obs_2_i        (obs_2_i),
    .obs_3_i        (obs_3_i),
    .reward_i       (reward_i),
    .rand_fraction_i(rand_fraction_i),
    .rand_pick_i    (rand_pick_i),
    .action_o       (action_o),
    .explore_prob_o (explore_prob_o),
    .state_error_o  (state_error_o),
    .done_o         (done_o)
  );
endmodule
`default_nettype wire

/* hdl/qla_checker.sv */
// Port-level checker of the agent and its bind to the top level.
`default_nettype none
module qla_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic [3:0]  action_o,
  input wire logic        state_error_o
);
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result shown while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_err_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && state_error_o) |-> action_o == 4'd0)
    else $error("error result with nonzero action");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o && !done_o)
    else $error("request not taken up");
endmodule

bind tabular_q_learning_agent_top qla_checker u_qla_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .action_o     (action_o),
  .state_error_o(state_error_o)
);
`default_nettype wire
